// ----- rtl/aarm_pkg.sv -----
// Types, constants and per-stage step functions of the axis-angle rotation matrix pipeline.
`default_nettype none

package aarm_pkg;

    // CORDIC iteration count, limited to the size of the arctangent table
    localparam int CORDIC_STEPS = 16;
    localparam int STEPS_USED   = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;

    // Stage map of the pipeline
    localparam int ST_SETUP   = 1;
    localparam int ST_SQRT0   = 2;
    localparam int SQRT_ITERS = 32;
    localparam int ST_DIVSET  = ST_SQRT0 + SQRT_ITERS;
    localparam int ST_DIV0    = ST_DIVSET + 1;
    localparam int DIV_BITS   = 31;
    localparam int ST_NORM    = ST_DIV0 + DIV_BITS;
    localparam int ST_MUL1    = ST_NORM + 1;
    localparam int ST_MUL2    = ST_MUL1 + 1;
    localparam int ST_OUT     = ST_MUL2 + 1;
    localparam int NSTAGE     = ST_OUT + 1;

    // Q2.30 values with headroom
    typedef logic signed [33:0] q_t;

    localparam q_t        ONE_Q     = 34'sd1073741824;
    localparam q_t        CORDIC_K  = 34'sd652032874;
    localparam logic [30:0] ONE_U31 = 31'd1073741824;

    // Arctangent of 2^-i in units of 2^32 per turn
    localparam logic [29:0] ATAN_TURNS [32] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
        30'd21354465, 30'd10680862, 30'd5340245, 30'd2670163, 30'd1335087,
        30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
        30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163,
        30'd81, 30'd41, 30'd20, 30'd10, 30'd5, 30'd3, 30'd1, 30'd1, 30'd0
    };

    typedef struct packed {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        logic [15:0]        ang;
        logic [31:0]        sqx;
        logic [31:0]        sqy;
        logic [31:0]        sqz;
        logic               degen;
        logic               flip;
        logic [63:0]        rad;
        logic [63:0]        root;
        q_t                 x;
        q_t                 y;
        logic signed [33:0] z;
        logic [2:0][60:0]   rem;
        logic [2:0][30:0]   quo;
        q_t [2:0]           n;
        q_t                 c;
        q_t                 s;
        q_t                 omc;
        q_t [2:0]           p;
        q_t [2:0]           nn;
        q_t [2:0]           sn;
        q_t [2:0]           qq;
        q_t [2:0]           dd;
        logic [8:0][15:0]   m;
    } stage_t;

    // Q2.30 product, rounded half up
    function automatic q_t mulq(input q_t a, input q_t b);
        logic signed [67:0] pr;
        pr = a * b;
        pr = pr + 68'sd536870912;
        return q_t'(pr[63:30]);
    endfunction

    // Q2.30 sum or difference to saturated Q1.15
    function automatic logic [15:0] to_q15(input q_t a, input q_t b, input logic sub);
        logic signed [34:0] t;
        logic signed [19:0] r;
        t = sub ? (35'(a) - 35'(b)) : (35'(a) + 35'(b));
        t = t + 35'sd16384;
        r = t[34:15];
        if (r > 20'sd32767)
            return 16'h7FFF;
        else if (r < -20'sd32768)
            return 16'h8000;
        else
            return r[15:0];
    endfunction

    // Combinational work between stage k-1 and stage k
    function automatic stage_t stage_fn(input int k, input stage_t pv);
        stage_t             o;
        logic [31:0]        sum;
        logic [63:0]        bitv;
        logic [63:0]        trial;
        logic [15:0]        angf;
        q_t                 dx;
        q_t                 dy;
        logic signed [15:0] a3 [3];
        logic [15:0]        mag;
        logic [60:0]        dv;
        logic [30:0]        q;
        q_t                 nv;
        int                 i;
        int                 j;
        o = pv;
        a3[0] = pv.ax;
        a3[1] = pv.ay;
        a3[2] = pv.az;

        // sum of squares, angle folding and CORDIC start
        if (k == ST_SETUP)
        begin
            sum     = pv.sqx + pv.sqy + pv.sqz;
            o.rad   = {2'b00, sum, 30'd0};
            o.root  = '0;
            o.degen = (sum == 32'd0);
            angf    = pv.ang + 16'd16384;
            o.flip  = angf[15];
            angf    = {pv.ang[15] ^ angf[15], pv.ang[14:0]};
            o.z     = {{2{angf[15]}}, angf, 16'd0};
            o.x     = CORDIC_K;
            o.y     = '0;
        end

        // one pair of radicand bits per stage
        if (k >= ST_SQRT0 && k < ST_DIVSET)
        begin
            i     = k - ST_SQRT0;
            bitv  = 64'd1 << (62 - 2 * i);
            trial = pv.root + bitv;
            if (pv.rad >= trial)
            begin
                o.rad  = pv.rad - trial;
                o.root = (pv.root >> 1) + bitv;
            end
            else
            begin
                o.root = pv.root >> 1;
            end
        end

        // one CORDIC rotation per stage, alongside the square root
        if (k >= ST_SQRT0 && k < ST_SQRT0 + STEPS_USED)
        begin
            i  = k - ST_SQRT0;
            dx = pv.y >>> i;
            dy = pv.x >>> i;
            if (!pv.z[33])
            begin
                o.x = pv.x - dx;
                o.y = pv.y + dy;
                o.z = pv.z - 34'(ATAN_TURNS[i]);
            end
            else
            begin
                o.x = pv.x + dx;
                o.y = pv.y - dy;
                o.z = pv.z + 34'(ATAN_TURNS[i]);
            end
        end

        // rounded dividends for the three axis components
        if (k == ST_DIVSET)
        begin
            for (int r = 0; r < 3; r++)
            begin
                mag      = a3[r][15] ? (~a3[r] + 16'd1) : a3[r];
                o.rem[r] = {mag, 45'd0} + 61'(pv.root[30:1]);
                o.quo[r] = '0;
            end
        end

        // one quotient bit per stage
        if (k >= ST_DIV0 && k < ST_NORM)
        begin
            j  = DIV_BITS - 1 - (k - ST_DIV0);
            dv = 61'(pv.root[30:0]) << j;
            for (int r = 0; r < 3; r++)
            begin
                if (pv.rem[r] >= dv)
                begin
                    o.rem[r]    = pv.rem[r] - dv;
                    o.quo[r][j] = 1'b1;
                end
            end
        end

        // clamp, restore sign, fold sine and cosine back
        if (k == ST_NORM)
        begin
            for (int r = 0; r < 3; r++)
            begin
                q = (pv.quo[r] > ONE_U31) ? ONE_U31 : pv.quo[r];
                nv = q_t'({3'b000, q});
                if (pv.degen)
                    o.n[r] = '0;
                else
                    o.n[r] = a3[r][15] ? -nv : nv;
            end
            o.c   = pv.flip ? -pv.x : pv.x;
            o.s   = pv.flip ? -pv.y : pv.y;
            o.omc = ONE_Q - (pv.flip ? -pv.x : pv.x);
        end

        // first products
        if (k == ST_MUL1)
        begin
            for (int r = 0; r < 3; r++)
            begin
                o.p[r]  = mulq(pv.n[r], pv.n[r]);
                o.sn[r] = mulq(pv.n[r], pv.s);
            end
            o.nn[0] = mulq(pv.n[0], pv.n[1]);
            o.nn[1] = mulq(pv.n[0], pv.n[2]);
            o.nn[2] = mulq(pv.n[1], pv.n[2]);
        end

        // second products
        if (k == ST_MUL2)
        begin
            for (int r = 0; r < 3; r++)
            begin
                o.qq[r] = mulq(pv.nn[r], pv.omc);
                o.dd[r] = mulq(ONE_Q - pv.p[r], pv.c);
            end
        end

        // matrix elements
        if (k == ST_OUT)
        begin
            o.m[0] = to_q15(pv.p[0], pv.dd[0], 1'b0);
            o.m[1] = to_q15(pv.qq[0], pv.sn[2], 1'b0);
            o.m[2] = to_q15(pv.qq[1], pv.sn[1], 1'b1);
            o.m[3] = to_q15(pv.qq[0], pv.sn[2], 1'b1);
            o.m[4] = to_q15(pv.p[1], pv.dd[1], 1'b0);
            o.m[5] = to_q15(pv.qq[2], pv.sn[0], 1'b0);
            o.m[6] = to_q15(pv.qq[1], pv.sn[1], 1'b0);
            o.m[7] = to_q15(pv.qq[2], pv.sn[0], 1'b1);
            o.m[8] = to_q15(pv.p[2], pv.dd[2], 1'b0);
        end
        return o;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/axis_angle_rotation_matrix_unit.sv -----
// Top level: pipelined axis-angle to rotation matrix unit.
`default_nettype none

// Takes one axis/angle transaction per cycle unless the output is stalled,
// and returns the nine Q1.15 elements of the transposed Rodrigues rotation
// matrix (a rotation by the negated angle), plus a flag for an all-zero axis
// (which gives cos on the diagonal). The pipeline is NSTAGE = 70 register
// stages long: one for the squares, one for setup, 32 for the bit-pair square
// root (CORDIC rotations run alongside it), one for the dividends, 31 for the
// quotient bits of the three normalising divides, one for clamping, two
// multiplier stages and the output register. The whole pipeline advances
// together, so a stalled output holds every stage and the input.
module axis_angle_rotation_matrix_unit
    import aarm_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [15:0] axis_x,
    input  wire logic signed [15:0] axis_y,
    input  wire logic signed [15:0] axis_z,
    input  wire logic [15:0]        angle,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [15:0]      m00,
    output logic signed [15:0]      m01,
    output logic signed [15:0]      m02,
    output logic signed [15:0]      m10,
    output logic signed [15:0]      m11,
    output logic signed [15:0]      m12,
    output logic signed [15:0]      m20,
    output logic signed [15:0]      m21,
    output logic signed [15:0]      m22,
    output logic                    degenerate
);

    stage_t             stg_reg  [NSTAGE];
    stage_t             stg_next [NSTAGE];
    logic [NSTAGE-1:0]  vld_reg;
    logic               adv;

    // advance everything unless the output transaction is blocked
    assign adv      = !vld_reg[ST_OUT] || out_ready;
    assign in_ready = adv;

    // capture the input and square the components
    always_comb
    begin
        stg_next[0]     = '0;
        stg_next[0].ax  = axis_x;
        stg_next[0].ay  = axis_y;
        stg_next[0].az  = axis_z;
        stg_next[0].ang = angle;
        stg_next[0].sqx = unsigned'(32'(axis_x * axis_x));
        stg_next[0].sqy = unsigned'(32'(axis_y * axis_y));
        stg_next[0].sqz = unsigned'(32'(axis_z * axis_z));
        for (int k = 1; k < NSTAGE; k++)
        begin
            stg_next[k] = stage_fn(k, stg_reg[k-1]);
        end
    end

    // move valid bits along with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NSTAGE-2:0], in_valid};
        end
    end

    // stage payload, held while stalled
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < NSTAGE; k++)
            begin
                stg_reg[k] <= stg_next[k];
            end
        end
    end

    // drive the result transaction from the last stage
    assign out_valid  = vld_reg[ST_OUT];
    assign m00        = stg_reg[ST_OUT].m[0];
    assign m01        = stg_reg[ST_OUT].m[1];
    assign m02        = stg_reg[ST_OUT].m[2];
    assign m10        = stg_reg[ST_OUT].m[3];
    assign m11        = stg_reg[ST_OUT].m[4];
    assign m12        = stg_reg[ST_OUT].m[5];
    assign m20        = stg_reg[ST_OUT].m[6];
    assign m21        = stg_reg[ST_OUT].m[7];
    assign m22        = stg_reg[ST_OUT].m[8];
    assign degenerate = stg_reg[ST_OUT].degen;

endmodule

`default_nettype wire
